// ===== rtl/core/pcrg_pkg.sv =====
package pcrg_pkg;

    localparam int COORD_INT_BITS  = 12;
    localparam int COORD_FRAC_BITS = 4;
    localparam int COORD_W         = COORD_INT_BITS + COORD_FRAC_BITS;

    localparam int SAMPLE_W = 16;
    localparam int XR_W     = (COORD_W < SAMPLE_W) ? COORD_W : SAMPLE_W;

    localparam int RES_W  = 13;
    localparam int COMP_W = 16;
    localparam int VEC_W  = 3 * COMP_W;
    localparam int POS_W  = 32;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;

    localparam int DIR_W    = 16;
    localparam int DIR_FRAC = 14;

    localparam logic [IDX_W-1:0] REG_FORWARD  = 3'd0;
    localparam logic [IDX_W-1:0] REG_RIGHT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_UP       = 3'd2;
    localparam logic [IDX_W-1:0] REG_POS_XY   = 3'd3;
    localparam logic [IDX_W-1:0] REG_POS_Z    = 3'd4;
    localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd5;
    localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd6;

    localparam logic [RES_W-1:0] WIDTH_RST  = 13'd1920;
    localparam logic [RES_W-1:0] HEIGHT_RST = 13'd1080;

    // pixel scale W*S and centred numerator 2*x - S*(1+W)
    localparam int DX_W  = RES_W + COORD_FRAC_BITS;
    localparam int NX_W  = ((XR_W + 1 > DX_W + 1) ? XR_W + 1 : DX_W + 1) + 1;
    localparam int PFF_W = 2 * DX_W;
    localparam int PR_W  = NX_W + DX_W;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic        [PFF_W-1:0] p_ff;
        logic signed [PR_W-1:0]  p_r;
        logic signed [PR_W-1:0]  p_t;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/core/pcrg_front.sv =====
module pcrg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pcrg_pkg::SAMPLE_W-1:0] i_sample_x,
    input  logic [pcrg_pkg::SAMPLE_W-1:0] i_sample_y,
    input  logic [pcrg_pkg::RES_W-1:0]    i_width,
    input  logic [pcrg_pkg::RES_W-1:0]    i_height,
    input  pcrg_pkg::t_qstat              i_qstat,
    output logic                          o_push,
    output pcrg_pkg::t_qent               o_push_data
);
    import pcrg_pkg::*;

    logic                   en;
    logic                   r_v1, r_v2;
    logic [RES_W-1:0]       w_eff, h_eff;
    logic [DX_W-1:0]        n_dx, n_dy, r_dx, r_dy;
    logic signed [NX_W-1:0] n_nx, n_ny, r_nx, r_ny;
    t_qent                  n_ent, r_ent;

    assign en         = !(r_v2 && i_qstat.full);
    assign o_in_stall = !en;
    assign o_push     = r_v2 && !i_qstat.full;
    assign o_push_data = r_ent;

    always_comb begin
        // a zero resolution counts as one pixel
        w_eff = (i_width == '0) ? RES_W'(1) : i_width;
        h_eff = (i_height == '0) ? RES_W'(1) : i_height;
        n_dx  = DX_W'(w_eff) << COORD_FRAC_BITS;
        n_dy  = DX_W'(h_eff) << COORD_FRAC_BITS;
        n_nx  = $signed(NX_W'({XR_W'(i_sample_x), 1'b0})
              - (NX_W'({1'b0, w_eff} + (RES_W+1)'(1)) << COORD_FRAC_BITS));
        n_ny  = $signed(NX_W'({XR_W'(i_sample_y), 1'b0})
              - (NX_W'({1'b0, h_eff} + (RES_W+1)'(1)) << COORD_FRAC_BITS));
    end

    always_comb begin
        n_ent.p_ff = PFF_W'(r_dx) * PFF_W'(r_dy);
        n_ent.p_r  = PR_W'(r_nx) * PR_W'($signed({1'b0, r_dy}));
        n_ent.p_t  = PR_W'(r_ny) * PR_W'($signed({1'b0, r_dx}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_nx  <= n_nx;
            r_ny  <= n_ny;
            r_ent <= n_ent;
        end
    end

endmodule

// ===== rtl/core/pcrg_queue.sv =====
module pcrg_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcrg_pkg::t_qent  i_push_data,
    input  logic             i_pop,
    output pcrg_pkg::t_qent  o_pop_data,
    output pcrg_pkg::t_qstat o_qstat
);
    import pcrg_pkg::*;

    t_qent           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_qstat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_pop_data    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_AW'(1);
            if (i_pop)  r_rp <= r_rp + Q_AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + (Q_AW+1)'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_qstat.full) else $error("item pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty) else $error("item popped from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/core/pcrg_back.sv =====
module pcrg_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcrg_pkg::t_qstat                   i_qstat,
    output logic                               o_pop,
    input  pcrg_pkg::t_qent                    i_pop_data,
    input  logic [pcrg_pkg::VEC_W-1:0]         i_forward,
    input  logic [pcrg_pkg::VEC_W-1:0]         i_right,
    input  logic [pcrg_pkg::VEC_W-1:0]         i_up,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [pcrg_pkg::DIR_W-1:0]  o_dir_x,
    output logic signed [pcrg_pkg::DIR_W-1:0]  o_dir_y,
    output logic signed [pcrg_pkg::DIR_W-1:0]  o_dir_z,
    output logic                               o_zero_length
);
    import pcrg_pkg::*;

    localparam int LP_W     = COMP_W + PR_W;
    localparam int C_W      = LP_W + 2;
    localparam int MAG_W    = C_W;
    localparam int CH_W     = 8;
    localparam int N_CH     = (MAG_W + CH_W - 1) / CH_W;
    localparam int CHP_W    = $clog2(CH_W);
    localparam int TOP_W    = $clog2(N_CH * CH_W);
    localparam int NM_W     = 31;
    localparam int NORM_TOP = NM_W - 1;
    localparam int SQ_W     = 64;
    localparam int LEN_W    = 32;
    localparam int Q_W      = DIR_FRAC + 1;
    localparam int NUM_W    = NM_W + DIR_FRAC + 1;
    localparam int DV_W     = LEN_W + Q_W;
    localparam int SQ_ST    = LEN_W;
    localparam int DV_ST    = Q_W;
    localparam int V_DINIT  = 8 + SQ_ST;
    localparam int N_ST     = V_DINIT + 1 + DV_ST + 1;

    typedef struct packed {
        logic [2:0][NM_W-1:0] m;
        logic [2:0]           neg;
        logic                 zero;
    } t_side;

    logic            en;
    logic [N_ST-1:0] r_vld;

    assign en          = !(r_vld[N_ST-1] && i_out_stall);
    assign o_pop       = en && !i_qstat.empty;
    assign o_out_valid = r_vld[N_ST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N_ST-2:0], o_pop};
        end
    end

    // lane products with the basis vectors
    logic signed [LP_W-1:0] r_lp [3][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_lp[i][0] <= LP_W'($signed(i_forward[COMP_W*i +: COMP_W]))
                            * LP_W'($signed({1'b0, i_pop_data.p_ff}));
                r_lp[i][1] <= LP_W'($signed(i_right[COMP_W*i +: COMP_W]))
                            * LP_W'(i_pop_data.p_r);
                r_lp[i][2] <= LP_W'($signed(i_up[COMP_W*i +: COMP_W]))
                            * LP_W'(i_pop_data.p_t);
            end
        end
    end

    // component sum, sign and magnitude
    logic signed [C_W-1:0] c_sum [3];
    logic [MAG_W-1:0]      r_mag1 [3];
    logic [2:0]            r_neg1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_sum[i] = C_W'(r_lp[i][0]) + C_W'(r_lp[i][1]) + C_W'(r_lp[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_neg1[i] <= c_sum[i][C_W-1];
                r_mag1[i] <= c_sum[i][C_W-1] ? MAG_W'(-c_sum[i]) : MAG_W'(c_sum[i]);
            end
        end
    end

    // leading one of the largest magnitude equals that of the OR of all three
    logic [MAG_W-1:0] r_or;
    logic [MAG_W-1:0] r_mag2 [3];
    logic [2:0]       r_neg2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_or   <= r_mag1[0] | r_mag1[1] | r_mag1[2];
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
        end
    end

    logic [N_CH*CH_W-1:0] or_pad;
    logic [N_CH-1:0]      n_cnz, r_cnz;
    logic [CHP_W-1:0]     n_cpos [N_CH];
    logic [CHP_W-1:0]     r_cpos [N_CH];
    logic [MAG_W-1:0]     r_mag3 [3];
    logic [2:0]           r_neg3;

    always_comb begin
        or_pad = (N_CH*CH_W)'(r_or);
        for (int k = 0; k < N_CH; k++) begin
            n_cnz[k]  = |or_pad[k*CH_W +: CH_W];
            n_cpos[k] = '0;
            for (int j = 0; j < CH_W; j++) begin
                if (or_pad[k*CH_W + j]) n_cpos[k] = CHP_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cnz  <= n_cnz;
            r_cpos <= n_cpos;
            r_mag3 <= r_mag2;
            r_neg3 <= r_neg2;
        end
    end

    logic [TOP_W-1:0] n_top, r_top;
    logic [MAG_W-1:0] r_mag4 [3];
    logic [2:0]       r_neg4;
    logic             r_zero4;

    always_comb begin
        n_top = '0;
        for (int k = 0; k < N_CH; k++) begin
            if (r_cnz[k]) n_top = TOP_W'(k * CH_W) + TOP_W'(r_cpos[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_top   <= n_top;
            r_zero4 <= ~|r_cnz;
            r_mag4  <= r_mag3;
            r_neg4  <= r_neg3;
        end
    end

    // common shift puts the leading one at bit NORM_TOP, truncating below
    t_side r_sd5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sd5.m[i] <= NM_W'({r_mag4[i], {NORM_TOP{1'b0}}} >> r_top);
            end
            r_sd5.neg  <= r_neg4;
            r_sd5.zero <= r_zero4;
        end
    end

    logic [2*NM_W-1:0] r_sq [3];
    t_side             r_sd6;
    logic [SQ_W-1:0]   r_sum;
    t_side             r_sd7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*NM_W)'(r_sd5.m[i]) * (2*NM_W)'(r_sd5.m[i]);
            end
            r_sd6 <= r_sd5;
            r_sum <= SQ_W'(r_sq[0]) + SQ_W'(r_sq[1]) + SQ_W'(r_sq[2]);
            r_sd7 <= r_sd6;
        end
    end

    // square root, one root bit per stage, remainder kept as n - root^2
    logic [SQ_W-1:0]  s_rem_in  [SQ_ST];
    logic [LEN_W-1:0] s_root_in [SQ_ST];
    t_side            s_sd_in   [SQ_ST];
    logic [SQ_W+1:0]  s_trial   [SQ_ST];
    logic [SQ_W-1:0]  s_rem_nx  [SQ_ST];
    logic [LEN_W-1:0] s_root_nx [SQ_ST];
    logic [SQ_W-1:0]  r_srem    [SQ_ST];
    logic [LEN_W-1:0] r_sroot   [SQ_ST];
    t_side            r_ssd     [SQ_ST];

    always_comb begin
        int b;
        s_rem_in[0]  = r_sum;
        s_root_in[0] = '0;
        s_sd_in[0]   = r_sd7;
        for (int k = 1; k < SQ_ST; k++) begin
            s_rem_in[k]  = r_srem[k-1];
            s_root_in[k] = r_sroot[k-1];
            s_sd_in[k]   = r_ssd[k-1];
        end
        for (int k = 0; k < SQ_ST; k++) begin
            b = LEN_W - 1 - k;
            s_trial[k] = ((SQ_W+2)'(s_root_in[k]) << (b + 1)) | ((SQ_W+2)'(1) << (2 * b));
            if ((SQ_W+2)'(s_rem_in[k]) >= s_trial[k]) begin
                s_rem_nx[k]  = s_rem_in[k] - SQ_W'(s_trial[k]);
                s_root_nx[k] = s_root_in[k] | (LEN_W'(1) << b);
            end else begin
                s_rem_nx[k]  = s_rem_in[k];
                s_root_nx[k] = s_root_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_srem  <= s_rem_nx;
            r_sroot <= s_root_nx;
            r_ssd   <= s_sd_in;
        end
    end

    // rounded quotient: numerator m*2^14 + len/2
    logic [NUM_W-1:0] r_num [3];
    logic [LEN_W-1:0] r_len;
    t_side            r_dsd0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= NUM_W'({r_ssd[SQ_ST-1].m[i], {DIR_FRAC{1'b0}}})
                          + NUM_W'(r_sroot[SQ_ST-1] >> 1);
            end
            r_len  <= r_sroot[SQ_ST-1];
            r_dsd0 <= r_ssd[SQ_ST-1];
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    logic [NUM_W-1:0] d_rem_in [DV_ST][3];
    logic [Q_W-1:0]   d_q_in   [DV_ST][3];
    logic [LEN_W-1:0] d_len_in [DV_ST];
    t_side            d_sd_in  [DV_ST];
    logic [DV_W-1:0]  d_dv     [DV_ST];
    logic [NUM_W-1:0] d_rem_nx [DV_ST][3];
    logic [Q_W-1:0]   d_q_nx   [DV_ST][3];
    logic [NUM_W-1:0] r_drem   [DV_ST][3];
    logic [Q_W-1:0]   r_dq     [DV_ST][3];
    logic [LEN_W-1:0] r_dlen   [DV_ST];
    t_side            r_dsd    [DV_ST];

    always_comb begin
        int b;
        for (int i = 0; i < 3; i++) begin
            d_rem_in[0][i] = r_num[i];
            d_q_in[0][i]   = '0;
        end
        d_len_in[0] = r_len;
        d_sd_in[0]  = r_dsd0;
        for (int j = 1; j < DV_ST; j++) begin
            d_rem_in[j] = r_drem[j-1];
            d_q_in[j]   = r_dq[j-1];
            d_len_in[j] = r_dlen[j-1];
            d_sd_in[j]  = r_dsd[j-1];
        end
        for (int j = 0; j < DV_ST; j++) begin
            b = Q_W - 1 - j;
            d_dv[j] = DV_W'(d_len_in[j]) << b;
            for (int i = 0; i < 3; i++) begin
                if (DV_W'(d_rem_in[j][i]) >= d_dv[j]) begin
                    d_rem_nx[j][i] = d_rem_in[j][i] - NUM_W'(d_dv[j]);
                    d_q_nx[j][i]   = d_q_in[j][i] | (Q_W'(1) << b);
                end else begin
                    d_rem_nx[j][i] = d_rem_in[j][i];
                    d_q_nx[j][i]   = d_q_in[j][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drem <= d_rem_nx;
            r_dq   <= d_q_nx;
            r_dlen <= d_len_in;
            r_dsd  <= d_sd_in;
        end
    end

    // output register; a zero direction reads as zero whatever the divider gave
    logic signed [DIR_W-1:0] r_dir [3];
    logic                    r_zl;
    t_side                   fin_sd;

    assign fin_sd = r_dsd[DV_ST-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (fin_sd.zero) begin
                    r_dir[i] <= '0;
                end else if (fin_sd.neg[i]) begin
                    r_dir[i] <= -$signed(DIR_W'(r_dq[DV_ST-1][i]));
                end else begin
                    r_dir[i] <= $signed(DIR_W'(r_dq[DV_ST-1][i]));
                end
            end
            r_zl <= fin_sd.zero;
        end
    end

    assign o_dir_x       = r_dir[0];
    assign o_dir_y       = r_dir[1];
    assign o_dir_z       = r_dir[2];
    assign o_zero_length = r_zl;

`ifndef SYNTHESIS
    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_length |-> (o_dir_x == '0 && o_dir_y == '0 && o_dir_z == '0))
        else $error("zero-length item with non-zero direction");
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_zero_length |->
            (o_dir_x <= 16'sd16384 && o_dir_x >= -16'sd16384 &&
             o_dir_y <= 16'sd16384 && o_dir_y >= -16'sd16384 &&
             o_dir_z <= 16'sd16384 && o_dir_z >= -16'sd16384))
        else $error("direction component beyond unit length");
    a_len_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_DINIT] && !r_dsd0.zero |-> r_len[LEN_W-1:LEN_W-2] != 2'b00)
        else $error("vector length below normalised range");
`endif

endmodule

// ===== rtl/core/pinhole_camera_ray_generator.sv =====
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    i_sample_x, i_sample_y
// result    out        o_out_valid / i_out_stall  o_dir_x/y/z, o_origin_x/y/z, o_zero_length
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; an item passes
// 2 front stages, the queue and 57 back stages set by the 32-stage square root and
// 15-stage divider. Synchronous active-low reset empties all stages.
// An output stall freezes the back pipeline; the 4-entry queue and the front
// keep taking items until full.
module pinhole_camera_ray_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pcrg_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [pcrg_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pcrg_pkg::SAMPLE_W-1:0]      i_sample_x,
    input  logic [pcrg_pkg::SAMPLE_W-1:0]      i_sample_y,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [pcrg_pkg::DIR_W-1:0]  o_dir_x,
    output logic signed [pcrg_pkg::DIR_W-1:0]  o_dir_y,
    output logic signed [pcrg_pkg::DIR_W-1:0]  o_dir_z,
    output logic signed [pcrg_pkg::POS_W-1:0]  o_origin_x,
    output logic signed [pcrg_pkg::POS_W-1:0]  o_origin_y,
    output logic signed [pcrg_pkg::POS_W-1:0]  o_origin_z,
    output logic                               o_zero_length
);
    import pcrg_pkg::*;

    logic [VEC_W-1:0]   r_forward, r_right, r_up;
    logic [2*POS_W-1:0] r_pos_xy;
    logic [POS_W-1:0]   r_pos_z;
    logic [RES_W-1:0]   r_width, r_height;

    logic   push, pop;
    t_qent  push_data, pop_data;
    t_qstat qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward <= '0;
            r_right   <= '0;
            r_up      <= '0;
            r_pos_xy  <= '0;
            r_pos_z   <= '0;
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FORWARD: r_forward <= i_cfg_data[VEC_W-1:0];
                REG_RIGHT:   r_right   <= i_cfg_data[VEC_W-1:0];
                REG_UP:      r_up      <= i_cfg_data[VEC_W-1:0];
                REG_POS_XY:  r_pos_xy  <= i_cfg_data[2*POS_W-1:0];
                REG_POS_Z:   r_pos_z   <= i_cfg_data[POS_W-1:0];
                REG_WIDTH:   r_width   <= i_cfg_data[RES_W-1:0];
                REG_HEIGHT:  r_height  <= i_cfg_data[RES_W-1:0];
                default: ;
            endcase
        end
    end

    // user must change position only while idle, unenforced; driven straight from registers
    assign o_origin_x = $signed(r_pos_xy[POS_W-1:0]);
    assign o_origin_y = $signed(r_pos_xy[2*POS_W-1:POS_W]);
    assign o_origin_z = $signed(r_pos_z);

    pcrg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    pcrg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_qstat     (qstat)
    );

    pcrg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .i_pop_data    (pop_data),
        .i_forward     (r_forward),
        .i_right       (r_right),
        .i_up          (r_up),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_dir_x       (o_dir_x),
        .o_dir_y       (o_dir_y),
        .o_dir_z       (o_dir_z),
        .o_zero_length (o_zero_length)
    );

endmodule

// ===== tb/pcrg_ray_monitor.sv =====
`timescale 1ns / 100ps

module pcrg_ray_monitor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pcrg_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [pcrg_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [pcrg_pkg::SAMPLE_W-1:0]      i_sample_x,
    input  logic [pcrg_pkg::SAMPLE_W-1:0]      i_sample_y,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [pcrg_pkg::DIR_W-1:0]  i_dir_x,
    input  logic signed [pcrg_pkg::DIR_W-1:0]  i_dir_y,
    input  logic signed [pcrg_pkg::DIR_W-1:0]  i_dir_z,
    input  logic signed [pcrg_pkg::POS_W-1:0]  i_origin_x,
    input  logic signed [pcrg_pkg::POS_W-1:0]  i_origin_y,
    input  logic signed [pcrg_pkg::POS_W-1:0]  i_origin_z,
    input  logic                               i_zero_length,
    output int                                 o_mismatches,
    output int                                 o_rays_pending
);
    import pcrg_pkg::*;

    typedef struct packed {
        logic [DIR_W-1:0] dx;
        logic [DIR_W-1:0] dy;
        logic [DIR_W-1:0] dz;
        logic [POS_W-1:0] ox;
        logic [POS_W-1:0] oy;
        logic [POS_W-1:0] oz;
        logic             zl;
    } t_ray;

    logic [VEC_W-1:0] fwd_q, right_q, up_q;
    logic [63:0]      pos_xy_q;
    logic [POS_W-1:0] pos_z_q;
    logic [RES_W-1:0] width_q, height_q;
    t_ray             rays_due[$];

    function automatic longint lane(logic [VEC_W-1:0] v, int i);
        return longint'($signed(v[16*i +: 16]));
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_ray trace_ray(logic [SAMPLE_W-1:0] sx, logic [SAMPLE_W-1:0] sy);
        longint          w, h, xr, yr, sw, sh, nx, ny, c;
        longint unsigned mag[3], mmax, sum, len, q;
        logic [15:0]     d[3];
        bit              neg[3];
        int              top;
        t_ray            r;
        w = (width_q == 0) ? 1 : longint'(width_q);
        h = (height_q == 0) ? 1 : longint'(height_q);
        xr = longint'(sx[COORD_W-1:0]);
        yr = longint'(sy[COORD_W-1:0]);
        sw = w << COORD_FRAC_BITS;
        sh = h << COORD_FRAC_BITS;
        nx = 2 * xr - (longint'(1) << COORD_FRAC_BITS) * (1 + w);
        ny = 2 * yr - (longint'(1) << COORD_FRAC_BITS) * (1 + h);
        mmax = 0;
        for (int i = 0; i < 3; i++) begin
            c = lane(fwd_q, i) * sw * sh + lane(right_q, i) * nx * sh
              + lane(up_q, i) * ny * sw;
            neg[i] = c < 0;
            mag[i] = neg[i] ? longint'(-c) : longint'(c);
            if (mag[i] > mmax) mmax = mag[i];
        end
        if (mmax == 0) begin
            d = '{16'h0, 16'h0, 16'h0};
            r.zl = 1'b1;
        end else begin
            top = 0;
            sum = 0;
            while ((mmax >> top) > 1) top++;
            for (int i = 0; i < 3; i++) begin
                if (top > 30) mag[i] >>= (top - 30);
                else mag[i] <<= (30 - top);
                sum += mag[i] * mag[i];
            end
            len = root_floor(sum);
            for (int i = 0; i < 3; i++) begin
                q = ((mag[i] << 14) + (len >> 1)) / len;
                d[i] = neg[i] ? 16'(-q) : 16'(q);
            end
            r.zl = 1'b0;
        end
        r.dx = d[0];
        r.dy = d[1];
        r.dz = d[2];
        r.ox = pos_xy_q[31:0];
        r.oy = pos_xy_q[63:32];
        r.oz = pos_z_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_ray got, want;
        if (!i_rst_n) begin
            fwd_q    <= '0;
            right_q  <= '0;
            up_q     <= '0;
            pos_xy_q <= '0;
            pos_z_q  <= '0;
            width_q  <= WIDTH_RST;
            height_q <= HEIGHT_RST;
            o_mismatches = 0;
            rays_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_dir_x, i_dir_y, i_dir_z, i_origin_x, i_origin_y, i_origin_z,
                        i_zero_length};
                if (rays_due.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("unexpected ray: %h", got);
                end else begin
                    want = rays_due.pop_front();
                    if (got !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("ray mismatch: exp %h %h %h %h %h %h %b, got %h %h %h %h %h %h %b",
                                want.dx, want.dy, want.dz, want.ox, want.oy, want.oz, want.zl,
                                got.dx, got.dy, got.dz, got.ox, got.oy, got.oz, got.zl);
                    end
                end
            end
            // prediction uses the settings in force before this edge
            if (i_in_valid && !i_in_stall)
                rays_due.push_back(trace_ray(i_sample_x, i_sample_y));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FORWARD: fwd_q    <= i_cfg_data[VEC_W-1:0];
                    REG_RIGHT:   right_q  <= i_cfg_data[VEC_W-1:0];
                    REG_UP:      up_q     <= i_cfg_data[VEC_W-1:0];
                    REG_POS_XY:  pos_xy_q <= i_cfg_data;
                    REG_POS_Z:   pos_z_q  <= i_cfg_data[POS_W-1:0];
                    REG_WIDTH:   width_q  <= i_cfg_data[RES_W-1:0];
                    REG_HEIGHT:  height_q <= i_cfg_data[RES_W-1:0];
                    default: ;
                endcase
            end
        end
        o_rays_pending = rays_due.size();
    end

endmodule

// ===== tb/pinhole_camera_ray_generator_test.sv =====
`timescale 1ns / 100ps

module pinhole_camera_ray_generator_test;
    import pcrg_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [IDX_W-1:0]         i_cfg_idx = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [SAMPLE_W-1:0]      i_sample_x = '0;
    logic [SAMPLE_W-1:0]      i_sample_y = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DIR_W-1:0]  o_dir_x, o_dir_y, o_dir_z;
    logic signed [POS_W-1:0]  o_origin_x, o_origin_y, o_origin_z;
    logic                     o_zero_length;
    int                       mismatches, rays_pending;
    bit                       quiet = 0;
    bit                       hold_req = 0;
    int                       cur_w = WIDTH_RST, cur_h = HEIGHT_RST;

    always #10 i_clk = ~i_clk;

    pinhole_camera_ray_generator uut (.*);

    pcrg_ray_monitor mon (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_sample_x, .i_sample_y,
        .i_out_valid(o_out_valid), .i_out_stall, .i_dir_x(o_dir_x), .i_dir_y(o_dir_y),
        .i_dir_z(o_dir_z), .i_origin_x(o_origin_x), .i_origin_y(o_origin_y),
        .i_origin_z(o_origin_z), .i_zero_length(o_zero_length),
        .o_mismatches(mismatches), .o_rays_pending(rays_pending)
    );

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // result side back-pressure
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            i_out_stall <= 1'b1;
            for (int k = 0; k < 300; k++) @(negedge i_clk);
            i_out_stall <= 1'b0;
            hold_req = 0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic push_sample(logic [15:0] sx, logic [15:0] sy);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_x <= sx;
        i_sample_y <= sy;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (rays_pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WIDTH) cur_w = val[RES_W-1:0];
        if (idx == REG_HEIGHT) cur_h = val[RES_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic setup(logic [47:0] f, logic [47:0] r, logic [47:0] u, int w, int h);
        write_reg(REG_FORWARD, {16'h0, f});
        write_reg(REG_RIGHT, {16'h0, r});
        write_reg(REG_UP, {16'h0, u});
        write_reg(REG_POS_XY, {$urandom, $urandom});
        write_reg(REG_POS_Z, {$urandom, $urandom});
        write_reg(REG_WIDTH, 64'(w));
        write_reg(REG_HEIGHT, 64'(h));
    endtask

    function automatic logic [47:0] rand_vec();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // mostly random, sometimes on the image centre line so one axis cancels
    task automatic random_sample;
        logic [15:0] sx, sy;
        int w, h;
        w = (cur_w == 0) ? 1 : cur_w;
        h = (cur_h == 0) ? 1 : cur_h;
        sx = $urandom;
        sy = $urandom;
        case ($urandom_range(0, 9))
            0: sx = 16'(8 * (1 + w));
            1: sy = 16'(8 * (1 + h));
            2: sx = 16'($urandom_range(0, 16 * w + 16));
            3: sy = 16'($urandom_range(0, 16 * h + 16));
            default: ;
        endcase
        push_sample(sx, sy);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: all basis vectors zero, every ray has zero length
        push_sample(16'h0, 16'h0);
        push_sample(16'hFFFF, 16'hFFFF);
        push_sample(16'h5A5A, 16'hA5A5);
        drain();

        // axis-aligned camera
        setup(48'h2000_0000_0000, 48'h0000_0000_2000, 48'h0000_2000_0000, 1920, 1080);
        push_sample(16'h0, 16'h0);
        push_sample(16'hFFFF, 16'hFFFF);
        push_sample(16'(8 * 1921), 16'(8 * 1081));
        push_sample(16'h0008, 16'hFFF8);
        push_sample(16'hAAAA, 16'h5555);
        drain();

        // no forward axis, sample at centre: zero direction
        setup(48'h0, 48'h0000_0000_2000, 48'h0000_2000_0000, 0, 0);
        push_sample(16'h0010, 16'h0010);
        push_sample(16'h0000, 16'hFFFF);
        push_sample(16'hFFFF, 16'h0000);
        drain();

        // largest magnitudes, with largest and oversize resolution, then with a one-pixel image
        setup(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_8000_7FFF, 8191, 4096);
        push_sample(16'h0, 16'hFFFF);
        push_sample(16'hFFFF, 16'h0);
        push_sample(16'h8010, 16'h7FF0);
        drain();
        setup(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 1, 1);
        push_sample(16'h0, 16'h0);
        push_sample(16'h0018, 16'h0008);
        push_sample(16'hFFFF, 16'hFFFF);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            quiet = (ph == 9);
            case (ph % 4)
                0: setup(rand_vec(), rand_vec(), rand_vec(),
                         $urandom_range(0, 8191), $urandom_range(0, 8191));
                1: setup(rand_vec(), rand_vec(), rand_vec(),
                         $urandom_range(1, 64), $urandom_range(1, 64));
                2: setup({16'($urandom_range(0, 255)), 32'h0}, rand_vec(), 48'h0,
                         $urandom_range(1, 4096), $urandom_range(1, 4096));
                default: setup(rand_vec(), rand_vec(), rand_vec(), 1920, 1080);
            endcase
            if (ph == 3) hold_req = 1;
            for (int n = 0; n < 105; n++) random_sample();
            drain();
        end

        if (mismatches == 0 && rays_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
